// ----- rtl/core/duleb_pkg.sv -----
// ----------------------------------------------------------------------------
// Delta ULEB128 encoder package
// Widths, byte-coding constants, the queue entry type and the byte counter.
// ----------------------------------------------------------------------------
`default_nettype none

package duleb_pkg;

    localparam int VALUE_W     = 32;
    localparam int BYTE_W      = 8;
    localparam int GROUP_BITS  = 7;
    localparam int MAX_BYTES   = 5;
    localparam int COUNT_W     = $clog2(MAX_BYTES + 1);

    localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] MORE_FLAG  = 8'h80;

    // Queue between the classifier and the byte serializer.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef logic [COUNT_W-1:0] byte_count_t;

    typedef struct packed {
        logic [VALUE_W-1:0] coded;
        byte_count_t        nbytes;
    } coded_entry_t;

    // Number of 7-bit groups needed for a coded value; zero still takes one byte.
    function automatic byte_count_t count_bytes(input logic [VALUE_W-1:0] coded);
        byte_count_t n;
        if (coded[31:28] != '0) begin
            n = COUNT_W'(5);
        end else if (coded[27:21] != '0) begin
            n = COUNT_W'(4);
        end else if (coded[20:14] != '0) begin
            n = COUNT_W'(3);
        end else if (coded[13:7] != '0) begin
            n = COUNT_W'(2);
        end else begin
            n = COUNT_W'(1);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/duleb_if.sv -----
// ----------------------------------------------------------------------------
// Delta ULEB128 encoder channels
// Valid/ready channels for input positions and for encoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface duleb_in_if;
    logic                           valid;
    logic                           ready;
    logic [duleb_pkg::VALUE_W-1:0]  value;
    logic                           first_of_list;

    modport source (output valid, output value, output first_of_list, input ready);
    modport sink   (input valid, input value, input first_of_list, output ready);
endinterface

interface duleb_out_if;
    logic                           valid;
    logic                           ready;
    logic [duleb_pkg::BYTE_W-1:0]   code_byte;
    logic                           last_byte;

    modport source (output valid, output code_byte, output last_byte, input ready);
    modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/duleb_front.sv -----
// ----------------------------------------------------------------------------
// Delta ULEB128 front end
// Accepts positions, forms the delta against the previous position and
// classifies the coded value by its byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module duleb_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    duleb_in_if.sink                value_stream,
    output duleb_pkg::coded_entry_t push_data,
    output logic                    push_valid,
    input  wire logic               push_ready
);
    import duleb_pkg::*;

    logic [VALUE_W-1:0] prev_reg;
    logic [VALUE_W-1:0] prev_next;
    logic [VALUE_W-1:0] coded;
    logic               accept;

    assign value_stream.ready = push_ready;
    assign accept             = value_stream.valid && push_ready;

    always_comb
    begin
        coded = value_stream.first_of_list ? value_stream.value
                                           : value_stream.value - prev_reg;
    end

    assign push_valid       = value_stream.valid;
    assign push_data.coded  = coded;
    assign push_data.nbytes = count_bytes(coded);

    always_comb
    begin
        prev_next = accept ? value_stream.value : prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> prev_reg == $past(value_stream.value))
        else $error("previous position not updated on an accepted beat");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_data.nbytes != '0) &&
                       (push_data.nbytes <= COUNT_W'(MAX_BYTES)))
        else $error("byte count out of range");

endmodule

`default_nettype wire

// ----- rtl/core/duleb_queue.sv -----
// ----------------------------------------------------------------------------
// Delta ULEB128 entry queue
// Short FIFO of classified values between the front end and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module duleb_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire duleb_pkg::coded_entry_t push_data,
    input  wire logic                    push_valid,
    output logic                         push_ready,
    output duleb_pkg::coded_entry_t      pop_data,
    output logic                         pop_valid,
    input  wire logic                    pop_ready
);
    import duleb_pkg::*;

    coded_entry_t       entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue fill count exceeds depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count missed a push");

endmodule

`default_nettype wire

// ----- rtl/core/duleb_back.sv -----
// ----------------------------------------------------------------------------
// Delta ULEB128 back end
// Takes classified values from the queue and emits one 7-bit group per
// cycle while the output does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module duleb_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire duleb_pkg::coded_entry_t pop_data,
    input  wire logic                    pop_valid,
    output logic                         pop_ready,
    duleb_out_if.source                  code_stream
);
    import duleb_pkg::*;

    logic               work_valid_reg, work_valid_next;
    logic [VALUE_W-1:0] work_data_reg, work_data_next;
    byte_count_t        work_left_reg, work_left_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  code_byte_reg, code_byte_next;
    logic               last_byte_reg, last_byte_next;
    logic               emit;
    logic               emit_last;
    logic               pop;

    // The output register may load when it is empty or its beat is taken.
    assign emit      = work_valid_reg && (!out_valid_reg || code_stream.ready);
    assign emit_last = work_left_reg == COUNT_W'(1);
    assign pop_ready = !work_valid_reg || (emit && emit_last);
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_data_next  = work_data_reg;
        work_left_next  = work_left_reg;
        if (pop)
        begin
            work_valid_next = 1'b1;
            work_data_next  = pop_data.coded;
            work_left_next  = pop_data.nbytes;
        end
        else if (emit)
        begin
            work_valid_next = !emit_last;
            work_data_next  = work_data_reg >> GROUP_BITS;
            work_left_next  = work_left_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        code_byte_next = code_byte_reg;
        last_byte_next = last_byte_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            code_byte_next = (work_data_reg[BYTE_W-1:0] & GROUP_MASK)
                           | (emit_last ? '0 : MORE_FLAG);
            last_byte_next = emit_last;
        end
        else if (code_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_data_reg <= work_data_next;
        work_left_reg <= work_left_next;
        code_byte_reg <= code_byte_next;
        last_byte_reg <= last_byte_next;
    end

    assign code_stream.valid     = out_valid_reg;
    assign code_stream.code_byte = code_byte_reg;
    assign code_stream.last_byte = last_byte_reg;

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg |-> (work_left_reg != '0) &&
                           (work_left_reg <= COUNT_W'(MAX_BYTES)))
        else $error("serializer byte count out of range");

    a_more_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> code_byte_reg[BYTE_W-1] == !last_byte_reg)
        else $error("continuation flag disagrees with last byte mark");

endmodule

`default_nettype wire

// ----- rtl/core/delta_uleb128_encoder.sv -----
// ----------------------------------------------------------------------------
// Delta ULEB128 encoder
// Codes 32-bit positions as deltas against the previous position and
// emits each coded value as 1 to 5 ULEB128 bytes.
// ----------------------------------------------------------------------------
//  Channel        Role     Payload
//  value_stream   sink     value[31:0], first_of_list
//  code_stream    source   code_byte[7:0], last_byte
//
//  The serializer emits an item's bytes in turn and loads the next item as
//  it emits the last byte, so the sustained rate is one byte per cycle while
//  the output does not stall. A position's first byte passes through a queue
//  entry, the work register and the output register before it is presented.
//  A two-entry queue lets the front end accept until full while output stalls.
//  Reset clears the previous position to zero and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_uleb128_encoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    duleb_in_if.sink    value_stream,
    duleb_out_if.source code_stream
);
    import duleb_pkg::*;

    coded_entry_t push_data;
    logic         push_valid;
    logic         push_ready;
    coded_entry_t pop_data;
    logic         pop_valid;
    logic         pop_ready;

    duleb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_stream (value_stream),
        .push_data    (push_data),
        .push_valid   (push_valid),
        .push_ready   (push_ready)
    );

    duleb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    duleb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_data    (pop_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .code_stream (code_stream)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_delta_uleb128_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta ULEB128 encoder testbench
// Sends lists of 32-bit positions and checks every encoded byte against a
// local delta/ULEB128 predictor. Both channels idle at random, with bursts
// that have no idle cycles at all.
// ----------------------------------------------------------------------------

import duleb_pkg::*;

class delta_code_checker;

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              last;
    } code_beat_t;

    logic [VALUE_W-1:0] last_position;
    code_beat_t         expected_beats[$];
    int unsigned        errors;

    function new();
        last_position = '0;
        errors        = 0;
    endfunction

    // Turns one accepted position into the byte beats it must produce.
    function void note_position(input logic [VALUE_W-1:0] position, input logic first);
        logic [VALUE_W-1:0] coded;
        logic [BYTE_W-1:0]  group;
        code_beat_t         beat;
        coded = first ? position : position - last_position;
        last_position = position;
        for (int n = 0; n < MAX_BYTES; n++)
        begin
            group = BYTE_W'(coded) & GROUP_MASK;
            coded = coded >> GROUP_BITS;
            if (coded != '0 && n < MAX_BYTES - 1)
            begin
                beat.code = group | MORE_FLAG;
                beat.last = 1'b0;
                expected_beats.insert(expected_beats.size(), beat);
            end
            else
            begin
                beat.code = group;
                beat.last = 1'b1;
                expected_beats.insert(expected_beats.size(), beat);
                break;
            end
        end
    endfunction

    function void check_byte(input logic [BYTE_W-1:0] code, input logic last);
        code_beat_t want;
        if (expected_beats.size() == 0)
        begin
            $display("%0t: unexpected byte beat, got code 0x%02h last %0b",
                     $time, code, last);
            errors++;
            return;
        end
        want = expected_beats.pop_front();
        if (code !== want.code)
        begin
            $display("%0t: code_byte wrong, expected 0x%02h, got 0x%02h",
                     $time, want.code, code);
            errors++;
        end
        if (last !== want.last)
        begin
            $display("%0t: last_byte wrong, expected %0b, got %0b",
                     $time, want.last, last);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return expected_beats.size();
    endfunction

endclass

module tb_delta_uleb128_encoder;

    localparam int unsigned ITEM_TARGET = 340;
    localparam int unsigned MAX_GAP     = 16;

    logic clk = 1'b0;
    logic rst_n;

    duleb_in_if  position_ch ();
    duleb_out_if byte_ch ();

    delta_uleb128_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_stream (position_ch),
        .code_stream  (byte_ch)
    );

    delta_code_checker  code_board;
    bit                 src_quiet;
    bit                 snk_quiet;
    logic [VALUE_W-1:0] list_tail;
    int unsigned        items_sent;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned draw_gap(input bit quiet);
        if (quiet || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Picks a step masked to 1 to 5 groups with equal odds; it codes in at most that many bytes.
    function automatic logic [VALUE_W-1:0] draw_step();
        int unsigned span;
        span = $urandom_range(1, MAX_BYTES);
        if (span == MAX_BYTES)
        begin
            return $urandom;
        end
        return $urandom & ((32'h1 << (GROUP_BITS * span)) - 32'h1);
    endfunction

    task automatic send_position(input logic [VALUE_W-1:0] position, input logic first);
        int unsigned gap;
        gap = draw_gap(src_quiet);
        if (gap != 0)
        begin
            position_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        position_ch.valid         <= 1'b1;
        position_ch.value         <= position;
        position_ch.first_of_list <= first;
        @(posedge clk);
        while (!position_ch.ready) @(posedge clk);
        code_board.note_position(position, first);
        list_tail = position;
        items_sent++;
    endtask

    task automatic send_list();
        int unsigned length;
        length = $urandom_range(1, 12);
        send_position($urandom, 1'b1);
        for (int unsigned k = 1; k < length; k++)
        begin
            send_position(list_tail + draw_step(), 1'b0);
        end
    endtask

    initial
    begin
        code_board        = new();
        rst_n             = 1'b0;
        position_ch.valid = 1'b0;
        position_ch.value = '0;
        position_ch.first_of_list = 1'b0;
        items_sent = 0;
        src_quiet  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no first mark since reset, the delta is taken against zero.
        send_position(32'h1234_5678, 1'b0);
        send_position(32'h0000_0000, 1'b1);
        send_position(32'h0000_007F, 1'b1);
        send_position(32'h0000_0080, 1'b1);
        send_position(32'h0000_3FFF, 1'b1);
        send_position(32'h0000_4000, 1'b1);
        send_position(32'h001F_FFFF, 1'b1);
        send_position(32'h0020_0000, 1'b1);
        send_position(32'h0FFF_FFFF, 1'b1);
        send_position(32'h1000_0000, 1'b1);
        send_position(32'hFFFF_FFFF, 1'b1);
        // A repeated position codes as a single zero byte.
        send_position(32'hFFFF_FFFF, 1'b0);
        send_position(32'h0000_0000, 1'b0);
        send_position(32'h0000_0005, 1'b0);
        // Stepping backwards wraps into a five-byte code.
        send_position(32'h0000_0003, 1'b0);
        send_position(32'h0000_0064, 1'b0);
        send_position(32'h8000_0000, 1'b1);
        send_position(32'h7FFF_FFFF, 1'b0);
        send_position(32'h8FFF_FFFF, 1'b0);
        send_position(32'h9FFF_FFFE, 1'b0);
        send_position(32'hAAAA_AAAA, 1'b1);
        send_position(32'h5555_5555, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                src_quiet = ~src_quiet;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                // Noise: any position, with or without a first mark.
                send_position($urandom, 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_list();
            end
        end
        position_ch.valid <= 1'b0;

        while (code_board.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (code_board.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin : byte_sink
        int unsigned gap;
        byte_ch.ready = 1'b0;
        snk_quiet     = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                snk_quiet = ~snk_quiet;
            end
            gap = draw_gap(snk_quiet);
            if (gap != 0)
            begin
                byte_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_ch.ready <= 1'b1;
            @(posedge clk);
            while (!byte_ch.valid) @(posedge clk);
            code_board.check_byte(byte_ch.code_byte, byte_ch.last_byte);
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
